// ===== sv/assert_macros.svh =====
// Assertion helpers for the ancestor engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked on every clock edge out of reset.
`define LCA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define LCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg
// Sizes, codes and helpers for the binary lifting ancestor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 10;
    localparam int NODE_W    = $clog2(NODES);
    localparam int FIELD_W   = 10;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int EDGE_CAP  = 2 * NODES - 2;
    localparam int EDGE_W    = $clog2(EDGE_CAP + 1);
    localparam int EDGE_AW   = $clog2(EDGE_CAP);
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int ANC_DEPTH = LEVELS * NODES;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);
    localparam int STK_W     = NODE_W + EDGE_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_BUILD = 3'd1,
        OP_LCA   = 3'd2,
        OP_KTH   = 3'd3,
        OP_LEVEL = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DEEP    = 2'd2,
        ST_UNBUILT = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_DONE, S_LV_CHK,
        S_LC_DA, S_LC_DB, S_LC_EQ, S_LC_T1, S_LC_T2,
        S_LC_K0, S_LC_K1, S_LC_K2, S_LC_F0, S_LC_F1,
        S_LF_BIT, S_LF_WT, S_LF_HI, S_LF_H1, S_LF_H2, S_LF_RES,
        S_B_CLR, S_B_INIT, S_B_TOP, S_B_TOP1, S_B_SCAN, S_B_SCAN1,
        S_B_VIS, S_B_PUSH, S_B_LVL, S_B_L0, S_B_L1, S_B_L2
    } t_state;

    // Address of the 2^k-th ancestor entry of node n.
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [LVL_W-1:0] k,
                                                   input logic [NODE_W-1:0] n);
        return ANC_AW'(k) * ANC_AW'(NODES) + ANC_AW'(n);
    endfunction

endpackage

`default_nettype wire

// ===== sv/lowest_common_ancestor_lifting.sv =====
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting
// Tree ancestor engine: edge store, depth first build of the lifting table,
// and lca, kth ancestor and ancestor-at-depth queries.
// ----------------------------------------------------------------------------
//  channel   | direction | beat contents
//  s_axis    | in        | tuser op, tdata first/second node, steps
//  m_axis    | out       | tuser status, tdata result node
//  cfg       | in        | root node write, no handshake
//
//  Add edge, unused ops and queries before a build go from accept through the
//  execute state to the done state. Lifting tests each step bit and reads the
//  table once per set bit; lca then lifts both nodes level by level from the top.
//  Build: clearing pass over all NODES entries, then a depth first walk that
//  examines edges, checks neighbours, pushes and pops, then one pass over all
//  entries for each of LEVELS-1 levels, all bound by the single ancestor read port.
//  Reset is synchronous and active low; o_s_tready is low while an item runs.
//  A waiting result is held until taken while the next beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_common_ancestor_lifting (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [9:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // first_node, second_node, steps
    input  wire logic [2:0]  i_s_tuser,   // op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // result_node
    output logic [1:0]       o_m_tuser    // status
);

    lca_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [lca_pkg::NODE_W-1:0]  r_root, n_root;
    logic [lca_pkg::EDGE_W-1:0]  r_ecnt, n_ecnt;
    logic                        r_built, n_built;
    logic [lca_pkg::OP_W-1:0]    r_op, n_op;
    logic [lca_pkg::NODE_W-1:0]  r_a, n_a, r_b, n_b, r_n, n_n, r_ta, n_ta;
    logic [lca_pkg::FIELD_W-1:0] r_s, n_s, r_sv, n_sv, r_hi, n_hi;
    logic [lca_pkg::LVL_W-1:0]   r_k, n_k;
    logic [lca_pkg::NODE_W-1:0]  r_j, n_j, r_v, n_v, r_w, n_w;
    logic [lca_pkg::EDGE_W-1:0]  r_e, n_e;
    logic [lca_pkg::NODE_W:0]    r_sp, n_sp;
    logic [lca_pkg::NODE_W-1:0]  r_res, n_res, r_ores, n_ores;
    logic [lca_pkg::ST_W-1:0]    r_st, n_st, r_ost, n_ost;
    logic                        r_ovalid, n_ovalid;

    // memory ports
    logic                           edge_we;
    logic [lca_pkg::EDGE_AW-1:0]    edge_waddr, edge_raddr;
    logic [2*lca_pkg::NODE_W-1:0]   edge_wdata, edge_rdata;
    logic                           anc_we;
    logic [lca_pkg::ANC_AW-1:0]     anc_waddr, anc_raddr;
    logic [lca_pkg::NODE_W-1:0]     anc_wdata, anc_rdata;
    logic                           dep_we;
    logic [lca_pkg::NODE_W-1:0]     dep_waddr, dep_raddr, dep_wdata, dep_rdata;
    logic                           vis_we;
    logic [lca_pkg::NODE_W-1:0]     vis_waddr, vis_raddr;
    logic                           vis_wdata, vis_rdata;
    logic                           stk_we;
    logic [lca_pkg::NODE_W-1:0]     stk_waddr, stk_raddr;
    logic [lca_pkg::STK_W-1:0]      stk_wdata, stk_rdata;

    logic [lca_pkg::NODE_W-1:0]  ea, eb;
    logic [lca_pkg::FIELD_W-1:0] diff;

    lca_ram #(.W(2*lca_pkg::NODE_W), .DEPTH(lca_pkg::EDGE_CAP)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );
    lca_ram #(.W(lca_pkg::NODE_W), .DEPTH(lca_pkg::ANC_DEPTH)) u_anc (
        .i_clk(i_clk), .i_we(anc_we), .i_waddr(anc_waddr), .i_wdata(anc_wdata),
        .i_raddr(anc_raddr), .o_rdata(anc_rdata)
    );
    lca_ram #(.W(lca_pkg::NODE_W), .DEPTH(lca_pkg::NODES)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_waddr), .i_wdata(dep_wdata),
        .i_raddr(dep_raddr), .o_rdata(dep_rdata)
    );
    lca_ram #(.W(1), .DEPTH(lca_pkg::NODES)) u_vis (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );
    lca_ram #(.W(lca_pkg::STK_W), .DEPTH(lca_pkg::NODES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    assign o_s_tready = (r_state == lca_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = 16'(r_ores);
    assign o_m_tuser  = r_ost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lca_pkg::S_IDLE;
            r_ret    <= lca_pkg::S_IDLE;
            r_root   <= '0;
            r_ecnt   <= '0;
            r_built  <= 1'b0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_root   <= n_root;
            r_ecnt   <= n_ecnt;
            r_built  <= n_built;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
        r_op   <= n_op;
        r_a    <= n_a;
        r_b    <= n_b;
        r_n    <= n_n;
        r_ta   <= n_ta;
        r_s    <= n_s;
        r_sv   <= n_sv;
        r_hi   <= n_hi;
        r_k    <= n_k;
        r_j    <= n_j;
        r_v    <= n_v;
        r_w    <= n_w;
        r_e    <= n_e;
        r_res  <= n_res;
        r_st   <= n_st;
        r_ores <= n_ores;
        r_ost  <= n_ost;
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_root   = r_root;
        n_ecnt   = r_ecnt;
        n_built  = r_built;
        n_op     = r_op;
        n_a      = r_a;
        n_b      = r_b;
        n_n      = r_n;
        n_ta     = r_ta;
        n_s      = r_s;
        n_sv     = r_sv;
        n_hi     = r_hi;
        n_k      = r_k;
        n_j      = r_j;
        n_v      = r_v;
        n_w      = r_w;
        n_e      = r_e;
        n_sp     = r_sp;
        n_res    = r_res;
        n_st     = r_st;
        n_ores   = r_ores;
        n_ost    = r_ost;
        n_ovalid = r_ovalid & ~i_m_tready;

        edge_we    = 1'b0;
        edge_waddr = lca_pkg::EDGE_AW'(r_ecnt);
        edge_wdata = {r_b, r_a};
        edge_raddr = lca_pkg::EDGE_AW'(r_e);
        anc_we     = 1'b0;
        anc_waddr  = '0;
        anc_wdata  = '0;
        anc_raddr  = '0;
        dep_we     = 1'b0;
        dep_waddr  = '0;
        dep_wdata  = '0;
        dep_raddr  = '0;
        vis_we     = 1'b0;
        vis_waddr  = '0;
        vis_wdata  = 1'b0;
        vis_raddr  = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;

        ea   = edge_rdata[lca_pkg::NODE_W-1:0];
        eb   = edge_rdata[2*lca_pkg::NODE_W-1:lca_pkg::NODE_W];
        diff = '0;

        if (i_cfg_we) begin
            n_root = i_cfg_wdata[lca_pkg::NODE_W-1:0];
        end

        case (r_state)
            lca_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    // Node indices are reduced modulo NODES, a power of two.
                    n_op    = i_s_tuser;
                    n_a     = i_s_tdata[lca_pkg::NODE_W-1:0];
                    n_b     = i_s_tdata[10 +: lca_pkg::NODE_W];
                    n_s     = i_s_tdata[29:20];
                    n_state = lca_pkg::S_EXEC;
                end
            end
            lca_pkg::S_EXEC: begin
                n_res   = '0;
                n_st    = lca_pkg::ST_OK;
                n_state = lca_pkg::S_DONE;
                case (r_op)
                    lca_pkg::OP_ADD: begin
                        if (r_ecnt < lca_pkg::EDGE_W'(lca_pkg::EDGE_CAP)) begin
                            edge_we = 1'b1;
                            n_ecnt  = r_ecnt + 1'b1;
                            n_built = 1'b0;
                        end else begin
                            n_st = lca_pkg::ST_FULL;
                        end
                    end
                    lca_pkg::OP_BUILD: begin
                        n_j     = '0;
                        n_state = lca_pkg::S_B_CLR;
                    end
                    lca_pkg::OP_LCA, lca_pkg::OP_KTH, lca_pkg::OP_LEVEL: begin
                        if (!r_built) begin
                            n_st = lca_pkg::ST_UNBUILT;
                        end else if (r_op == lca_pkg::OP_KTH) begin
                            n_n     = r_a;
                            n_sv    = r_s;
                            n_hi    = lca_pkg::FIELD_W'(r_s >> lca_pkg::LEVELS);
                            n_k     = '0;
                            n_ret   = lca_pkg::S_LF_RES;
                            n_state = lca_pkg::S_LF_BIT;
                        end else begin
                            dep_raddr = r_a;
                            n_state   = (r_op == lca_pkg::OP_LCA) ? lca_pkg::S_LC_DA
                                                                  : lca_pkg::S_LV_CHK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lca_pkg::S_LV_CHK: begin
                if (r_s > lca_pkg::FIELD_W'(dep_rdata)) begin
                    n_res   = r_a;
                    n_st    = lca_pkg::ST_DEEP;
                    n_state = lca_pkg::S_DONE;
                end else begin
                    diff    = lca_pkg::FIELD_W'(dep_rdata) - r_s;
                    n_sv    = diff;
                    n_hi    = lca_pkg::FIELD_W'(diff >> lca_pkg::LEVELS);
                    n_n     = r_a;
                    n_k     = '0;
                    n_ret   = lca_pkg::S_LF_RES;
                    n_state = lca_pkg::S_LF_BIT;
                end
            end
            lca_pkg::S_LC_DA: begin
                n_ta      = dep_rdata;
                dep_raddr = r_b;
                n_state   = lca_pkg::S_LC_DB;
            end
            lca_pkg::S_LC_DB: begin
                // The deeper node is lifted; r_b keeps the other one.
                if (r_ta < dep_rdata) begin
                    n_n  = r_b;
                    n_b  = r_a;
                    diff = lca_pkg::FIELD_W'(dep_rdata - r_ta);
                end else begin
                    n_n  = r_a;
                    diff = lca_pkg::FIELD_W'(r_ta - dep_rdata);
                end
                n_sv    = diff;
                n_hi    = lca_pkg::FIELD_W'(diff >> lca_pkg::LEVELS);
                n_k     = '0;
                n_ret   = lca_pkg::S_LC_EQ;
                n_state = lca_pkg::S_LF_BIT;
            end
            lca_pkg::S_LC_EQ: begin
                if (r_n == r_b) begin
                    n_res   = r_n;
                    n_state = lca_pkg::S_DONE;
                end else begin
                    anc_raddr = lca_pkg::anc_addr(lca_pkg::LVL_W'(lca_pkg::LEVELS - 1), r_n);
                    n_state   = lca_pkg::S_LC_T1;
                end
            end
            lca_pkg::S_LC_T1: begin
                n_ta      = anc_rdata;
                anc_raddr = lca_pkg::anc_addr(lca_pkg::LVL_W'(lca_pkg::LEVELS - 1), r_b);
                n_state   = lca_pkg::S_LC_T2;
            end
            lca_pkg::S_LC_T2: begin
                if (r_ta != anc_rdata) begin
                    n_n     = r_ta;
                    n_b     = anc_rdata;
                    n_state = lca_pkg::S_LC_EQ;
                end else begin
                    n_k     = lca_pkg::LVL_W'(lca_pkg::LEVELS - 1);
                    n_state = lca_pkg::S_LC_K0;
                end
            end
            lca_pkg::S_LC_K0: begin
                anc_raddr = lca_pkg::anc_addr(r_k, r_n);
                n_state   = lca_pkg::S_LC_K1;
            end
            lca_pkg::S_LC_K1: begin
                n_ta      = anc_rdata;
                anc_raddr = lca_pkg::anc_addr(r_k, r_b);
                n_state   = lca_pkg::S_LC_K2;
            end
            lca_pkg::S_LC_K2: begin
                if (r_ta != anc_rdata) begin
                    n_n = r_ta;
                    n_b = anc_rdata;
                end
                if (r_k == '0) begin
                    n_state = lca_pkg::S_LC_F0;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = lca_pkg::S_LC_K0;
                end
            end
            lca_pkg::S_LC_F0: begin
                anc_raddr = lca_pkg::anc_addr('0, r_n);
                n_state   = lca_pkg::S_LC_F1;
            end
            lca_pkg::S_LC_F1: begin
                n_res   = anc_rdata;
                n_state = lca_pkg::S_DONE;
            end
            lca_pkg::S_LF_BIT: begin
                if (r_k == lca_pkg::LVL_W'(lca_pkg::LEVELS)) begin
                    n_state = lca_pkg::S_LF_HI;
                end else if (((r_sv >> r_k) & lca_pkg::FIELD_W'(1)) != '0) begin
                    anc_raddr = lca_pkg::anc_addr(r_k, r_n);
                    n_state   = lca_pkg::S_LF_WT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            lca_pkg::S_LF_WT: begin
                n_n     = anc_rdata;
                n_k     = r_k + 1'b1;
                n_state = lca_pkg::S_LF_BIT;
            end
            lca_pkg::S_LF_HI: begin
                // Steps beyond the table's reach go up two top-level jumps at a time.
                if (r_hi == '0) begin
                    n_state = r_ret;
                end else begin
                    anc_raddr = lca_pkg::anc_addr(lca_pkg::LVL_W'(lca_pkg::LEVELS - 1), r_n);
                    n_state   = lca_pkg::S_LF_H1;
                end
            end
            lca_pkg::S_LF_H1: begin
                anc_raddr = lca_pkg::anc_addr(lca_pkg::LVL_W'(lca_pkg::LEVELS - 1), anc_rdata);
                n_state   = lca_pkg::S_LF_H2;
            end
            lca_pkg::S_LF_H2: begin
                n_n     = anc_rdata;
                n_hi    = r_hi - 1'b1;
                n_state = lca_pkg::S_LF_HI;
            end
            lca_pkg::S_LF_RES: begin
                n_res   = r_n;
                n_state = lca_pkg::S_DONE;
            end
            lca_pkg::S_B_CLR: begin
                dep_we    = 1'b1;
                dep_waddr = r_j;
                anc_we    = 1'b1;
                anc_waddr = lca_pkg::anc_addr('0, r_j);
                anc_wdata = r_root;
                vis_we    = 1'b1;
                vis_waddr = r_j;
                if (r_j == lca_pkg::NODE_W'(lca_pkg::NODES - 1)) begin
                    n_state = lca_pkg::S_B_INIT;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            lca_pkg::S_B_INIT: begin
                vis_we    = 1'b1;
                vis_waddr = r_root;
                vis_wdata = 1'b1;
                stk_we    = 1'b1;
                stk_wdata = {r_root, lca_pkg::EDGE_W'(0)};
                n_sp      = (lca_pkg::NODE_W + 1)'(1);
                n_state   = lca_pkg::S_B_TOP;
            end
            lca_pkg::S_B_TOP: begin
                if (r_sp == '0) begin
                    n_k     = lca_pkg::LVL_W'(1);
                    n_state = lca_pkg::S_B_LVL;
                end else begin
                    stk_raddr = lca_pkg::NODE_W'(r_sp - 1'b1);
                    n_state   = lca_pkg::S_B_TOP1;
                end
            end
            lca_pkg::S_B_TOP1: begin
                n_v     = stk_rdata[lca_pkg::STK_W-1:lca_pkg::EDGE_W];
                n_e     = stk_rdata[lca_pkg::EDGE_W-1:0];
                n_state = lca_pkg::S_B_SCAN;
            end
            lca_pkg::S_B_SCAN: begin
                if (r_e < r_ecnt) begin
                    n_state = lca_pkg::S_B_SCAN1;
                end else begin
                    n_sp    = r_sp - 1'b1;
                    n_state = lca_pkg::S_B_TOP;
                end
            end
            lca_pkg::S_B_SCAN1: begin
                n_e     = r_e + 1'b1;
                n_state = lca_pkg::S_B_SCAN;
                if (ea == r_v) begin
                    n_w       = eb;
                    vis_raddr = eb;
                    n_state   = lca_pkg::S_B_VIS;
                end else if (eb == r_v) begin
                    n_w       = ea;
                    vis_raddr = ea;
                    n_state   = lca_pkg::S_B_VIS;
                end
            end
            lca_pkg::S_B_VIS: begin
                if (vis_rdata) begin
                    n_state = lca_pkg::S_B_SCAN;
                end else if (r_sp < (lca_pkg::NODE_W + 1)'(lca_pkg::NODES)) begin
                    stk_we    = 1'b1;
                    stk_waddr = lca_pkg::NODE_W'(r_sp - 1'b1);
                    stk_wdata = {r_v, r_e};
                    vis_we    = 1'b1;
                    vis_waddr = r_w;
                    vis_wdata = 1'b1;
                    dep_raddr = r_v;
                    n_state   = lca_pkg::S_B_PUSH;
                end else begin
                    n_sp    = r_sp - 1'b1;
                    n_state = lca_pkg::S_B_TOP;
                end
            end
            lca_pkg::S_B_PUSH: begin
                dep_we    = 1'b1;
                dep_waddr = r_w;
                dep_wdata = dep_rdata + 1'b1;
                anc_we    = 1'b1;
                anc_waddr = lca_pkg::anc_addr('0, r_w);
                anc_wdata = r_v;
                stk_we    = 1'b1;
                stk_waddr = r_sp[lca_pkg::NODE_W-1:0];
                stk_wdata = {r_w, lca_pkg::EDGE_W'(0)};
                n_v       = r_w;
                n_e       = '0;
                n_sp      = r_sp + 1'b1;
                n_state   = lca_pkg::S_B_SCAN;
            end
            lca_pkg::S_B_LVL: begin
                if (r_k == lca_pkg::LVL_W'(lca_pkg::LEVELS)) begin
                    n_built = 1'b1;
                    n_state = lca_pkg::S_DONE;
                end else begin
                    n_j     = '0;
                    n_state = lca_pkg::S_B_L0;
                end
            end
            lca_pkg::S_B_L0: begin
                anc_raddr = lca_pkg::anc_addr(r_k - 1'b1, r_j);
                n_state   = lca_pkg::S_B_L1;
            end
            lca_pkg::S_B_L1: begin
                anc_raddr = lca_pkg::anc_addr(r_k - 1'b1, anc_rdata);
                n_state   = lca_pkg::S_B_L2;
            end
            lca_pkg::S_B_L2: begin
                anc_we    = 1'b1;
                anc_waddr = lca_pkg::anc_addr(r_k, r_j);
                anc_wdata = anc_rdata;
                if (r_j == lca_pkg::NODE_W'(lca_pkg::NODES - 1)) begin
                    n_k     = r_k + 1'b1;
                    n_state = lca_pkg::S_B_LVL;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = lca_pkg::S_B_L0;
                end
            end
            lca_pkg::S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                    n_ost    = r_st;
                    n_state  = lca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lca_pkg::S_IDLE;
            end
        endcase
    end

`include "assert_macros.svh"

    `LCA_ASSERT(a_ecnt_cap, r_ecnt <= lca_pkg::EDGE_W'(lca_pkg::EDGE_CAP), "count too high")
    `LCA_ASSERT(a_sp_range, r_sp <= (lca_pkg::NODE_W + 1)'(lca_pkg::NODES), "stack too deep")
    `LCA_ASSERT_IMP(a_built, $rose(r_built), $past(r_state) == lca_pkg::S_B_LVL, "built early")
    `LCA_ASSERT_IMP(a_ecnt_exec, $past(r_state) != lca_pkg::S_EXEC, $stable(r_ecnt), "count moved")

endmodule

`default_nettype wire

// ===== sv/lca_ram.sv =====
// ----------------------------------------------------------------------------
// lca_ram
// Generic single write, single read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_ram #(
    parameter  int W     = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
